>>> rtl/page_framebuffer_glyph_blit_defines.svh
// Assertion macros for the page frame store blitter.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef PAGE_FRAMEBUFFER_GLYPH_BLIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_GLYPH_BLIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define PFGB_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfgb check failed");
// Next-cycle implication, disabled during reset
`define PFGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfgb check failed");
`else
`define PFGB_ASSERT(label, clk, rst, ante, cons)
`define PFGB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/pfgb_pkg.sv
package pfgb_pkg;

  // Command codes (s_tuser)
  localparam logic [1:0] CMD_FILL = 2'd0;
  localparam logic [1:0] CMD_DRAW = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Configuration register indexes
  localparam logic REG_ACTIVE_WIDTH = 1'b0;
  localparam logic REG_ACTIVE_PAGES = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] ACTIVE_WIDTH_RST = 8'd128;
  localparam logic [3:0] ACTIVE_PAGES_RST = 4'd8;

  // Glyphs this tall or taller reach into a third page when not page-aligned
  localparam logic [4:0] THIRD_PAGE_HEIGHT = 5'd10;
  localparam logic [7:0] FILLED_BYTE       = 8'hFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_DRAW,
    ST_DRAW_END,
    ST_READ,
    ST_DONE
  } state_t;

  // White ORs the bits in; black turns an empty byte solid, then clears the bits
  function automatic logic [7:0] merge_byte(input logic [7:0] old_byte,
                                            input logic [7:0] bits,
                                            input logic       white);
    logic [7:0] base;
    base = (old_byte == 8'h00) ? FILLED_BYTE : old_byte;
    return white ? (old_byte | bits) : (base & ~bits);
  endfunction

endpackage

>>> rtl/page_framebuffer_glyph_blit.sv
// Page-mode monochrome frame store with a glyph-column blitter.
// Input channel s_*: one beat is one command (fill, draw glyph column, read byte),
// selected by s_tuser. Output channel m_*: exactly one result beat per command,
// read byte in m_tdata and the clip flag in m_tuser.
// Config port cfg_we/cfg_index/cfg_data: user writes only while idle, unenforced.
// Commands are worked one at a time; the byte memory has one write port and one
// registered read port, and that port pair sets the work per command:
//   draw : three page reads issued on consecutive cycles, each merge written back
//          in the cycle after its read
//   read : one page read; fill: width * pages writes (limited active area)
//   clipped draw or read, empty fill, unused command: no memory access
// A new command is taken the cycle after the previous result enters the output
// register, even while that result still waits on m_tready.
// Reset: a clearing pass writes zero to every entry, one per cycle, covering all
// MAX_PAGES * 2**clog2(MAX_WIDTH) entries (1024 at the defaults); s_tready stays
// low meanwhile, config writes are taken as ever.
// Receiver stall: the result holds in the output register; a finished command
// waits for it to drain before loading its own result.
`include "page_framebuffer_glyph_blit_defines.svh"

module page_framebuffer_glyph_blit #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_PAGES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel
  input  logic        s_tvalid,
  output logic        s_tready,
  // column_bits[15:0], glyph_height[20:16], color[21], pos_x[29:22], pos_y[35:30]
  input  logic [39:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  // Result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0]
  output logic [7:0]  m_tdata,
  // clipped[0]
  output logic        m_tuser,
  // Configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int AW    = PW + CW;
  localparam int DEPTH = MAX_PAGES << CW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [8:0]    MAX_W9    = 9'(MAX_WIDTH);
  localparam logic [4:0]    MAX_P5    = 5'(MAX_PAGES);

  // Input fields
  logic [15:0] column_bits;
  logic [4:0]  glyph_height;
  logic        color;
  logic [7:0]  pos_x;
  logic [5:0]  pos_y;

  assign column_bits  = s_tdata[15:0];
  assign glyph_height = s_tdata[20:16];
  assign color        = s_tdata[21];
  assign pos_x        = s_tdata[29:22];
  assign pos_y        = s_tdata[35:30];

  // Configuration registers
  logic [7:0] active_width;
  logic [3:0] active_pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width <= pfgb_pkg::ACTIVE_WIDTH_RST;
      active_pages <= pfgb_pkg::ACTIVE_PAGES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfgb_pkg::REG_ACTIVE_WIDTH: active_width <= cfg_data;
        pfgb_pkg::REG_ACTIVE_PAGES: active_pages <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective width and page count, limited to the store size
  logic [8:0] width_eff;
  logic [4:0] pages_eff;

  assign width_eff = ({1'b0, active_width} > MAX_W9) ? MAX_W9 : {1'b0, active_width};
  assign pages_eff = ({1'b0, active_pages} > MAX_P5) ? MAX_P5 : {1'b0, active_pages};

  // Decode of the incoming beat
  logic [2:0]  in_page;
  logic [2:0]  in_shift;
  logic [23:0] in_shifted;
  logic        in_clip;
  logic        in_page_ok;
  logic [2:0]  in_en;
  logic        accept;

  assign in_page    = pos_y[5:3];
  assign in_shift   = pos_y[2:0];
  assign in_shifted = {8'h00, column_bits} << in_shift;
  assign in_clip    = ({1'b0, pos_x} >= width_eff);
  assign in_page_ok = ({2'b00, in_page} < pages_eff);
  assign in_en[0]   = in_page_ok;
  assign in_en[1]   = (in_shift != 3'd0) && (({2'b00, in_page} + 5'd1) < pages_eff);
  assign in_en[2]   = (in_shift != 3'd0) && (({2'b00, in_page} + 5'd2) < pages_eff) &&
                      (glyph_height >= pfgb_pkg::THIRD_PAGE_HEIGHT);
  assign accept     = s_tvalid && s_tready;

  // Command held for the duration of its work
  logic [1:0]       q_cmd;
  logic [2:0]       q_page;
  logic [CW-1:0]    q_col;
  logic [2:0][7:0]  q_bytes;
  logic [2:0]       q_en;
  logic             q_white;
  logic             q_clip;
  logic             q_rd_ok;

  always_ff @(posedge clk) begin
    if (accept) begin
      q_cmd   <= s_tuser;
      q_page  <= in_page;
      q_col   <= pos_x[CW-1:0];
      q_bytes <= in_shifted;
      q_en    <= in_en;
      q_white <= color;
      q_clip  <= in_clip && ((s_tuser == pfgb_pkg::CMD_DRAW) ||
                             (s_tuser == pfgb_pkg::CMD_READ));
      q_rd_ok <= !in_clip && in_page_ok;
    end
  end

  // Frame store: one write port, one registered read port
  logic [7:0]    mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Sequencer state and counters
  pfgb_pkg::state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic [PW-1:0] fill_page;
  logic [CW-1:0] fill_col;
  logic [1:0]    step;
  logic          out_load;

  // Draw write-back: page index of the byte being written
  logic [1:0] wsel;
  logic [4:0] wr_page_sum;
  logic [4:0] rd_page_sum;
  logic       fill_col_last;
  logic       fill_page_last;

  assign wsel           = (state == pfgb_pkg::ST_DRAW_END) ? 2'd2 : (step - 2'd1);
  assign wr_page_sum    = {2'b00, q_page} + {3'b000, wsel};
  assign rd_page_sum    = {2'b00, q_page} + {3'b000, step};
  assign fill_col_last  = ((9'(fill_col) + 9'd1) == width_eff);
  assign fill_page_last = ((5'(fill_page) + 5'd1) == pages_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfgb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = 8'h00;
    mem_re     = 1'b0;
    mem_raddr  = {rd_page_sum[PW-1:0], q_col};
    out_load   = 1'b0;
    unique case (state)
      pfgb_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = pfgb_pkg::ST_IDLE;
        end
      end
      pfgb_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (s_tuser)
            pfgb_pkg::CMD_FILL: begin
              if (width_eff == 9'd0 || pages_eff == 5'd0) begin
                state_next = pfgb_pkg::ST_DONE;
              end else begin
                state_next = pfgb_pkg::ST_FILL;
              end
            end
            pfgb_pkg::CMD_DRAW: begin
              state_next = in_clip ? pfgb_pkg::ST_DONE : pfgb_pkg::ST_DRAW;
            end
            pfgb_pkg::CMD_READ: begin
              state_next = (!in_clip && in_page_ok) ? pfgb_pkg::ST_READ
                                                    : pfgb_pkg::ST_DONE;
            end
            default: state_next = pfgb_pkg::ST_DONE;
          endcase
        end
      end
      pfgb_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {fill_page, fill_col};
        mem_wdata = q_white ? pfgb_pkg::FILLED_BYTE : 8'h00;
        if (fill_col_last && fill_page_last) begin
          state_next = pfgb_pkg::ST_DONE;
        end
      end
      pfgb_pkg::ST_DRAW: begin
        // read page+step, write back page+step-1 from the previous read
        mem_re    = 1'b1;
        mem_we    = (step != 2'd0) && q_en[wsel];
        mem_waddr = {wr_page_sum[PW-1:0], q_col};
        mem_wdata = pfgb_pkg::merge_byte(rd_data, q_bytes[wsel], q_white);
        if (step == 2'd2) begin
          state_next = pfgb_pkg::ST_DRAW_END;
        end
      end
      pfgb_pkg::ST_DRAW_END: begin
        mem_we     = q_en[2];
        mem_waddr  = {wr_page_sum[PW-1:0], q_col};
        mem_wdata  = pfgb_pkg::merge_byte(rd_data, q_bytes[2], q_white);
        state_next = pfgb_pkg::ST_DONE;
      end
      pfgb_pkg::ST_READ: begin
        // step is zero here, so the read address is the requested page
        mem_re     = 1'b1;
        state_next = pfgb_pkg::ST_DONE;
      end
      pfgb_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = pfgb_pkg::ST_IDLE;
        end
      end
      default: state_next = pfgb_pkg::ST_IDLE;
    endcase
  end

  // Clear sweep, fill walk and draw step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      fill_page <= '0;
      fill_col  <= '0;
      step      <= 2'd0;
    end else begin
      if (state == pfgb_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (accept) begin
        fill_page <= '0;
        fill_col  <= '0;
        step      <= 2'd0;
      end else if (state == pfgb_pkg::ST_FILL) begin
        if (fill_col_last) begin
          fill_col  <= '0;
          fill_page <= fill_page + PW'(1);
        end else begin
          fill_col <= fill_col + CW'(1);
        end
      end else if (state == pfgb_pkg::ST_DRAW) begin
        step <= step + 2'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= (q_cmd == pfgb_pkg::CMD_READ && q_rd_ok) ? rd_data : 8'h00;
      m_tuser <= q_clip;
    end
  end

  // State groups used by the checks
  logic draw_wb;
  logic quiet_state;
  logic done_stalled;

  assign draw_wb      = (state == pfgb_pkg::ST_DRAW) || (state == pfgb_pkg::ST_DRAW_END);
  assign quiet_state  = (state == pfgb_pkg::ST_IDLE) || (state == pfgb_pkg::ST_DONE) ||
                        (state == pfgb_pkg::ST_READ);
  assign done_stalled = (state == pfgb_pkg::ST_DONE) && m_tvalid && !m_tready;

  // Checks
  `PFGB_ASSERT(a_draw_page_in_range, clk, rst, mem_we && draw_wb, wr_page_sum < pages_eff)
  `PFGB_ASSERT(a_no_write_when_quiet, clk, rst, mem_we, !quiet_state)
  `PFGB_ASSERT_NEXT(a_result_waits, clk, rst, done_stalled, state == pfgb_pkg::ST_DONE)
  `PFGB_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != pfgb_pkg::ST_IDLE)

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_W = 128;
  localparam int MAX_P = 8;
  localparam int QUIET_LIMIT = 20000;
  localparam int NUM_PHASES = 9;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] bits;
    logic [4:0]  height;
    logic        color;
    logic [7:0]  x;
    logic [5:0]  y;
  } blit_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       clip;
  } blit_result_t;

  // Register settings per phase: width, pages, random command count
  int phase_width [NUM_PHASES] = '{128, 255, 1, 0, 64, 0, 200, 17, 128};
  int phase_pages [NUM_PHASES] = '{8, 15, 1, 0, 0, 8, 3, 8, 8};
  int phase_items [NUM_PHASES] = '{120, 100, 60, 30, 40, 30, 120, 120, 180};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  // Shadow copy of the frame store and of the active area
  logic [7:0]  frame_shadow [MAX_P*MAX_W];
  int unsigned shadow_width = int'(pfgb_pkg::ACTIVE_WIDTH_RST);
  int unsigned shadow_pages = int'(pfgb_pkg::ACTIVE_PAGES_RST);

  blit_cmd_t    cmd_queue [$];
  blit_result_t expected_results [$];
  blit_cmd_t    in_flight;
  blit_result_t predicted;
  blit_result_t oldest;
  idle_mode_t   idle_mode = IDLE_NONE;

  int error_count = 0;
  int quiet_cycles = 0;
  int n_fill = 0, n_draw = 0, n_read = 0, n_unused = 0, n_clipped = 0, n_checked = 0;

  page_framebuffer_glyph_blit #(
    .MAX_WIDTH(MAX_W),
    .MAX_PAGES(MAX_P)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int active_cols();
    return (shadow_width > MAX_W) ? MAX_W : shadow_width;
  endfunction

  function automatic int active_rows();
    return (shadow_pages > MAX_P) ? MAX_P : shadow_pages;
  endfunction

  // White sets the bits; black makes an empty byte solid, then clears them
  task automatic blend_into(input int pg, input int col, input logic [7:0] mask,
                            input logic white);
    logic [7:0] cur;
    cur = frame_shadow[pg*MAX_W + col];
    if (white) begin
      frame_shadow[pg*MAX_W + col] = cur | mask;
    end else begin
      frame_shadow[pg*MAX_W + col] =
        ((cur == 8'h00) ? pfgb_pkg::FILLED_BYTE : cur) & ~mask;
    end
  endtask

  // Works out the result of one command and updates the shadow store
  task automatic apply_command(input blit_cmd_t c, output blit_result_t r);
    int w;
    int np;
    int pg;
    int sh;
    logic [31:0] v;
    w  = active_cols();
    np = active_rows();
    pg = int'(c.y) / 8;
    sh = int'(c.y) % 8;
    v  = {16'h0000, c.bits};
    r.data = 8'h00;
    r.clip = 1'b0;
    case (c.cmd)
      pfgb_pkg::CMD_FILL: begin
        n_fill++;
        for (int p = 0; p < np; p++) begin
          for (int col = 0; col < w; col++) begin
            frame_shadow[p*MAX_W + col] = c.color ? pfgb_pkg::FILLED_BYTE : 8'h00;
          end
        end
      end
      pfgb_pkg::CMD_DRAW: begin
        n_draw++;
        if (int'(c.x) >= w) begin
          r.clip = 1'b1;
        end else begin
          if (pg < np) blend_into(pg, int'(c.x), 8'(v << sh), c.color);
          if (sh != 0 && pg + 1 < np) begin
            blend_into(pg + 1, int'(c.x), 8'(v >> (8 - sh)), c.color);
          end
          // third page only for tall glyphs
          if (sh != 0 && pg + 2 < np && c.height >= pfgb_pkg::THIRD_PAGE_HEIGHT) begin
            blend_into(pg + 2, int'(c.x), 8'(v >> (16 - sh)), c.color);
          end
        end
      end
      pfgb_pkg::CMD_READ: begin
        n_read++;
        if (int'(c.x) >= w) begin
          r.clip = 1'b1;
        end else if (pg < np) begin
          r.data = frame_shadow[pg*MAX_W + int'(c.x)];
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    if (r.clip) n_clipped++;
  endtask

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 53;
      IDLE_BOTH: return $urandom_range(99) < 25;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_hold();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 53;
      IDLE_BOTH: return $urandom_range(99) < 25;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic queue_cmd(input logic [1:0] cmd, input logic [15:0] bits,
                           input logic [4:0] height, input logic color,
                           input logic [7:0] x, input logic [5:0] y);
    blit_cmd_t c;
    c.cmd = cmd; c.bits = bits; c.height = height;
    c.color = color; c.x = x; c.y = y;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  // Mostly draws and reads, often on a few hot columns so reads see drawn bytes
  function automatic blit_cmd_t random_cmd();
    blit_cmd_t c;
    int roll;
    int w;
    w = active_cols();
    roll = $urandom_range(99);
    if (roll < 3)       c.cmd = pfgb_pkg::CMD_FILL;
    else if (roll < 55) c.cmd = pfgb_pkg::CMD_DRAW;
    else if (roll < 95) c.cmd = pfgb_pkg::CMD_READ;
    else                c.cmd = CMD_UNUSED;
    c.bits   = 16'($urandom);
    c.height = 5'($urandom_range(0, 31));
    c.color  = 1'($urandom_range(0, 1));
    c.y      = 6'($urandom_range(0, 63));
    roll = $urandom_range(9);
    if (w == 0 || roll < 2) begin
      c.x = 8'($urandom_range(0, 255));
    end else if (roll < 6) begin
      c.x = 8'($urandom_range(0, ((w < 8) ? w : 8) - 1));
    end else begin
      c.x = 8'($urandom_range(0, w - 1));
    end
    return c;
  endfunction

  // Sampled at the falling edge, clear of the clocked blocks
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Command driver: holds a beat until it is taken, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        apply_command(in_flight, predicted);
        expected_results.insert(expected_results.size(), predicted);
      end
      if (cmd_queue.size() != 0 && !sender_gap()) begin
        in_flight = cmd_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, in_flight.y, in_flight.x, in_flight.color,
                     in_flight.height, in_flight.bits};
        s_tuser  <= in_flight.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result beat with nothing pending (data %02h clip %0b)",
                               m_tdata, m_tuser));
        end else begin
          oldest = expected_results.pop_front();
          if (m_tdata !== oldest.data) begin
            flag_error($sformatf("read_data %02h, predicted %02h", m_tdata, oldest.data));
          end
          if (m_tuser !== oldest.clip) begin
            flag_error($sformatf("clipped %0b, predicted %0b", m_tuser, oldest.clip));
          end
        end
      end
      m_tready <= !receiver_hold();
    end
  end

  // Watchdog on cycles without any beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      // Both registers, pages with junk in the unused upper bits
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= pfgb_pkg::REG_ACTIVE_WIDTH;
      cfg_data  <= 8'(phase_width[ph]);
      @(posedge clk);
      cfg_index <= pfgb_pkg::REG_ACTIVE_PAGES;
      cfg_data  <= {4'($urandom), 4'(phase_pages[ph])};
      @(posedge clk);
      cfg_we    <= 1'b0;
      shadow_width = phase_width[ph] & 8'hFF;
      shadow_pages = phase_pages[ph] & 4'hF;
      @(negedge clk);
      idle_mode = idle_mode_t'(ph % 4);

      if (ph == 0) begin
        // Directed: store starts empty
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd0,   6'd0);
        queue_cmd(pfgb_pkg::CMD_DRAW, 16'hFFFF, 5'd16, 1'b1, 8'd0,   6'd0);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd0,   6'd0);
        // bottom row, corner column, shifted bits fall off the store
        queue_cmd(pfgb_pkg::CMD_DRAW, 16'hFFFF, 5'd31, 1'b1, 8'd127, 6'd63);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd127, 6'd56);
        queue_cmd(pfgb_pkg::CMD_READ, 16'hFFFF, 5'd31, 1'b1, 8'd127, 6'd63);
        // three pages, then black over it with a short glyph
        queue_cmd(pfgb_pkg::CMD_DRAW, 16'hA5C3, 5'd10, 1'b1, 8'd5,   6'd13);
        queue_cmd(pfgb_pkg::CMD_DRAW, 16'h0F0F, 5'd9,  1'b0, 8'd5,   6'd13);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd5,   6'd8);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd5,   6'd16);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd5,   6'd24);
        // black onto an empty byte
        queue_cmd(pfgb_pkg::CMD_DRAW, 16'h0001, 5'd0,  1'b0, 8'd6,   6'd0);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd6,   6'd0);
        // tall glyph whose third page lies past the last page
        queue_cmd(pfgb_pkg::CMD_DRAW, 16'hFFFF, 5'd16, 1'b1, 8'd9,   6'd53);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd9,   6'd48);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd9,   6'd56);
        // clipping on draw and read
        queue_cmd(pfgb_pkg::CMD_DRAW, 16'h1234, 5'd12, 1'b1, 8'd128, 6'd0);
        queue_cmd(pfgb_pkg::CMD_DRAW, 16'hFFFF, 5'd31, 1'b0, 8'd255, 6'd63);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd200, 6'd8);
        queue_cmd(CMD_UNUSED,         16'hFFFF, 5'd31, 1'b1, 8'd3,   6'd0);
        queue_cmd(pfgb_pkg::CMD_FILL, 16'h0000, 5'd0,  1'b1, 8'd0,   6'd0);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd127, 6'd56);
        queue_cmd(pfgb_pkg::CMD_FILL, 16'hFFFF, 5'd31, 1'b0, 8'd255, 6'd63);
        queue_cmd(pfgb_pkg::CMD_READ, 16'h0000, 5'd0,  1'b0, 8'd64,  6'd32);
      end
      for (int i = 0; i < phase_items[ph]; i++) begin
        cmd_queue.insert(cmd_queue.size(), random_cmd());
      end
    end

    wait_drained();
    repeat (32) @(posedge clk);
    if (expected_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("ran %0d fills, %0d draws, %0d reads, %0d unused commands (%0d clipped)",
             n_fill, n_draw, n_read, n_unused, n_clipped);
    $display("%0d register settings, %0d result beats checked", NUM_PHASES, n_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
